// File: hw/rtl/static_linked_list_engine_core_macros.svh
// ----------------------------------------------------------------------------
// Static linked list engine - assertion macros
// Shared concurrent assertion forms. Each use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define SLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// Static linked list engine - package
// Codes, command/status bundles and sizes shared by the engine modules.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int NODES_DEF = 64;

  localparam int REQ_W    = 2;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;
  localparam int S_DATA_W = 40;  // 2 + 6 + 32
  localparam int M_DATA_W = 40;  // 2 + 32, padded to bytes

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    RD_FREE, RD_HEAD, RD_CUR, RD_NODE, RD_PRED
  } rd_sel_t;

  typedef enum logic [1:0] {
    CUR_HOLD, CUR_HEAD, CUR_STEP
  } cur_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_FREE_AUX, WR_NODE_AUX2, WR_PRED_NODE, WR_PRED_AUX, WR_FREE_NODE
  } wr_op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_STATUS, OUT_ELEM
  } out_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RESP,
    S_I_FREE, S_WALK, S_WALK_W,
    S_I_NF, S_I_PN, S_I_W1, S_I_W2,
    S_R_NODE, S_R_NN, S_R_F, S_R_W1, S_R_W2, S_R_W3,
    S_D_FIRST, S_D_RD, S_D_OUT
  } state_t;

  typedef struct packed {
    logic            ld_req;
    logic            rd_en;
    rd_sel_t         rd_sel;
    cur_op_t         cur_op;
    logic            cnt_clr;
    logic            cnt_inc;
    logic            node_ld;
    logic            pred_ld;
    logic            aux_ld;
    logic            aux2_ld;
    wr_op_t          wr_op;
    logic            val_wr;
    logic            st_ld;
    logic [ST_W-1:0] st_val;
    out_op_t         out_op;
  } sll_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             pos_zero;
    logic             rd_zero;
    logic             steps_zero;
    logic             out_free;
    logic             cnt_last;
  } sll_stat_t;

endpackage

// File: hw/rtl/static_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// Static linked list engine - top level
// Cursor-linked list in a fixed node store with a free list; insert, remove
// and in-order dump requests.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tlast
//  s_*     | in  | req_type[1:0] position[7:2] value[39:8] | -
//  m_*     | out | status[1:0] element[33:2] zero[39:34]   | last
//
//  Insert and remove walk the link store up to the position, one registered
//  read per step; a dump walks it in list order, one read per element.
//  Reset: rst clears the state machine, the result valid flag and one valid
//  bit per link entry; no clearing pass, a request can enter the next cycle.
//  A stalled m_tready holds the result; the next request is taken while a
//  single-item result still waits. A dump holds off new requests until done.
// ----------------------------------------------------------------------------
module static_linked_list_engine_core #(
  parameter int NODES = sll_pkg::NODES_DEF  // node store depth, 4..65
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sll_pkg::S_DATA_W-1:0]  s_tdata,   // req_type, position, value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sll_pkg::M_DATA_W-1:0]  m_tdata,   // status, element, zero pad
  output logic                          m_tlast
);
  import sll_pkg::*;

  sll_cmd_t  cmd;
  sll_stat_t stat;

  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_element;

  // request field split
  logic [REQ_W-1:0]        in_req;
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_val;

  assign in_req = s_tdata[REQ_W-1:0];
  assign in_pos = s_tdata[REQ_W+POS_W-1:REQ_W];
  assign in_val = s_tdata[REQ_W+POS_W+VAL_W-1:REQ_W+POS_W];

  // control: request decode, walk sequencing, result hand-off
  sll_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // stores and working registers
  sll_datapath #(
    .NODES (NODES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_req      (in_req),
    .in_pos      (in_pos),
    .in_val      (in_val),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (m_tlast)
  );

  // result packing, padded to whole bytes
  assign m_tdata = {(M_DATA_W - ST_W - VAL_W)'(0), out_element, out_status};

endmodule

// File: hw/rtl/sll_datapath.sv
// ----------------------------------------------------------------------------
// Static linked list engine - datapath
// Link and value stores, walk cursor, node holders and the result register.
// ----------------------------------------------------------------------------
module sll_datapath #(
  parameter int NODES = sll_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sll_pkg::REQ_W-1:0]         in_req,
  input  logic [sll_pkg::POS_W-1:0]         in_pos,
  input  logic signed [sll_pkg::VAL_W-1:0]  in_val,
  input  sll_pkg::sll_cmd_t                 cmd,
  output sll_pkg::sll_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sll_pkg::ST_W-1:0]          out_status,
  output logic signed [sll_pkg::VAL_W-1:0]  out_element,
  output logic                              out_last
);
  import sll_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam logic [NW-1:0] HEAD      = NW'(NODES - 1);
  localparam logic [NW-1:0] FREE      = '0;
  localparam logic [NW-1:0] TAIL_FREE = NW'(NODES - 2);
  localparam logic [NW-1:0] CNT_END   = NW'(NODES - 3);

  logic [NW-1:0]    link_mem [NODES];
  logic [VAL_W-1:0] val_mem  [NODES];
  logic [NODES-1:0] link_vld;

  logic [REQ_W-1:0] req;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [POS_W-1:0] steps;
  logic [NW-1:0]    cur, node, pred, aux, aux2, cnt;
  logic [ST_W-1:0]  st;

  logic [NW-1:0]    rd_addr, rd_mem, rd_init, rdata;
  logic             rd_vld;
  logic [VAL_W-1:0] val_rd;
  logic [NW-1:0]    wr_addr, wr_data;
  logic             wr_en;

  // read address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_FREE: rd_addr = FREE;
      RD_HEAD: rd_addr = HEAD;
      RD_CUR:  rd_addr = cur;
      RD_NODE: rd_addr = node;
      RD_PRED: rd_addr = pred;
      default: rd_addr = FREE;
    endcase
  end

  // write address / data
  always_comb begin
    wr_en   = 1'b1;
    unique case (cmd.wr_op)
      WR_FREE_AUX:  begin wr_addr = FREE; wr_data = aux;  end
      WR_NODE_AUX2: begin wr_addr = node; wr_data = aux2; end
      WR_PRED_NODE: begin wr_addr = pred; wr_data = node; end
      WR_PRED_AUX:  begin wr_addr = pred; wr_data = aux;  end
      WR_FREE_NODE: begin wr_addr = FREE; wr_data = node; end
      default: begin
        wr_en   = 1'b0;
        wr_addr = FREE;
        wr_data = '0;
      end
    endcase
  end

  // stores: registered read, single write
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_mem  <= link_mem[rd_addr];
      val_rd  <= val_mem[rd_addr];
      rd_vld  <= link_vld[rd_addr];
      rd_init <= (rd_addr >= TAIL_FREE) ? '0 : rd_addr + NW'(1);
    end
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.val_wr) begin
      val_mem[node] <= val;
    end
  end

  // never-written link entries read as their reset chain value
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (wr_en) begin
      link_vld[wr_addr] <= 1'b1;
    end
  end

  assign rdata = rd_vld ? rd_mem : rd_init;

  // request, cursor and node holders
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req <= in_req;
      pos <= in_pos;
      val <= in_val;
    end
    unique case (cmd.cur_op)
      CUR_HEAD: begin
        cur   <= HEAD;
        steps <= pos - POS_W'(1);
      end
      CUR_STEP: begin
        cur   <= rdata;
        steps <= steps - POS_W'(1);
      end
      default: ;
    endcase
    if (cmd.cnt_clr) cnt <= '0;
    else if (cmd.cnt_inc) cnt <= cnt + NW'(1);
    if (cmd.node_ld) node <= rdata;
    if (cmd.pred_ld) pred <= cur;
    if (cmd.aux_ld)  aux  <= rdata;
    if (cmd.aux2_ld) aux2 <= rdata;
    if (cmd.st_ld)   st   <= cmd.st_val;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_op != OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.out_op)
      OUT_STATUS: begin
        out_status  <= st;
        out_element <= '0;
        out_last    <= 1'b1;
      end
      OUT_ELEM: begin
        out_status  <= ST_OK;
        out_element <= val_rd;
        out_last    <= (rdata == '0) || (cnt == CNT_END);
      end
      default: ;
    endcase
  end

  assign stat.req        = req;
  assign stat.pos_zero   = (pos == '0);
  assign stat.rd_zero    = (rdata == '0);
  assign stat.steps_zero = (steps == '0);
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.cnt_last   = (cnt == CNT_END);

endmodule

// File: hw/rtl/sll_controller.sv
// ----------------------------------------------------------------------------
// Static linked list engine - controller
// Sequences store reads, link walks, link rewrites and result hand-off.
// ----------------------------------------------------------------------------
module sll_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output sll_pkg::sll_cmd_t  cmd,
  input  sll_pkg::sll_stat_t stat
);
  import sll_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.ld_req = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.req == REQ_DUMP) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_D_FIRST;
        end else if (stat.req != REQ_INSERT && stat.req != REQ_REMOVE) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_OK;
          state_next = S_RESP;
        end else if (stat.pos_zero) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_RANGE;
          state_next = S_RESP;
        end else if (stat.req == REQ_INSERT) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FREE;
          state_next = S_I_FREE;
        end else begin
          cmd.cur_op = CUR_HEAD;
          state_next = S_WALK;
        end
      end
      S_I_FREE: begin
        if (stat.rd_zero) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_FULL;
          state_next = S_RESP;
        end else begin
          cmd.node_ld = 1'b1;
          cmd.cur_op  = CUR_HEAD;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.steps_zero) begin
          cmd.pred_ld = 1'b1;
          cmd.rd_en   = 1'b1;
          if (stat.req == REQ_INSERT) begin
            cmd.rd_sel = RD_NODE;
            state_next = S_I_NF;
          end else begin
            cmd.rd_sel = RD_CUR;
            state_next = S_R_NODE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = S_WALK_W;
        end
      end
      S_WALK_W: begin
        if (stat.rd_zero) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_RANGE;
          state_next = S_RESP;
        end else begin
          cmd.cur_op = CUR_STEP;
          state_next = S_WALK;
        end
      end
      S_I_NF: begin
        cmd.aux_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PRED;
        state_next = S_I_PN;
      end
      S_I_PN: begin
        cmd.aux2_ld = 1'b1;
        state_next  = S_I_W1;
      end
      S_I_W1: begin
        cmd.wr_op  = WR_FREE_AUX;
        cmd.val_wr = 1'b1;
        state_next = S_I_W2;
      end
      S_I_W2: begin
        cmd.wr_op  = WR_NODE_AUX2;
        state_next = S_R_W2;
      end
      S_R_NODE: begin
        if (stat.rd_zero) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_RANGE;
          state_next = S_RESP;
        end else begin
          cmd.node_ld = 1'b1;
          state_next  = S_R_NN;
        end
      end
      S_R_NN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NODE;
        state_next = S_R_F;
      end
      S_R_F: begin
        cmd.aux_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FREE;
        state_next = S_R_W1;
      end
      S_R_W1: begin
        cmd.aux2_ld = 1'b1;
        cmd.wr_op   = WR_PRED_AUX;
        state_next  = S_R_W2;
      end
      S_R_W2: begin
        // insert: link pred to new node; remove: link node to old free head
        if (stat.req == REQ_INSERT) begin
          cmd.wr_op = WR_PRED_NODE;
          cmd.st_ld = 1'b1;
          cmd.st_val = ST_OK;
          state_next = S_RESP;
        end else begin
          cmd.wr_op  = WR_NODE_AUX2;
          state_next = S_R_W3;
        end
      end
      S_R_W3: begin
        // removed node becomes the free head
        cmd.wr_op  = WR_FREE_NODE;
        cmd.st_ld  = 1'b1;
        cmd.st_val = ST_OK;
        state_next = S_RESP;
      end
      S_D_FIRST: begin
        if (stat.rd_zero) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_EMPTY;
          state_next = S_RESP;
        end else begin
          cmd.cur_op  = CUR_STEP;
          cmd.cnt_clr = 1'b1;
          state_next  = S_D_RD;
        end
      end
      S_D_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_next = S_D_OUT;
      end
      S_D_OUT: begin
        if (stat.out_free) begin
          cmd.out_op = OUT_ELEM;
          if (stat.rd_zero || stat.cnt_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.cur_op  = CUR_STEP;
            cmd.cnt_inc = 1'b1;
            state_next  = S_D_RD;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_op = OUT_STATUS;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/sll_checker.sv
// ----------------------------------------------------------------------------
// Static linked list engine - port checker
// Watches the top-level ports for result ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "static_linked_list_engine_core_macros.svh"

module sll_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [sll_pkg::S_DATA_W-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sll_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                          m_tlast
);
  import sll_pkg::*;

  logic [ST_W-1:0] m_status;
  assign m_status = m_tdata[ST_W-1:0];

  // stalled result holds
  `SLL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // error results carry no element and close the request
  `SLL_ASSERT_NOW(a_err_shape, m_tvalid && (m_status != ST_OK || m_tdata[M_DATA_W-1:ST_W+VAL_W] != '0), m_tdata[M_DATA_W-1:ST_W] == '0 && m_tlast, "bad error result")

  // mid-dump: only ok status, and no new request taken
  `SLL_ASSERT_NOW(a_dump_mid, m_tvalid && !m_tlast, m_status == ST_OK && !s_tready, "open dump overlaps request")

  // a taken request occupies the engine the next cycle
  `SLL_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready && s_tdata == $past(s_tdata) || !s_tready, "ready right after accept")

endmodule

bind static_linked_list_engine_core sll_checker u_sll_checker (.*);
